FILE: rtl/core/gwl_pkg.sv
// G-code word lexer package: token and code types, character constants,
// power-of-ten table. No dependencies.
`timescale 1ns / 1ps

package gwl_pkg;

  localparam int FRAC_DIGITS_DEF = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_F      = 8'h46;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;

  localparam int G_HOME = 28;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    LT_G      = 3'd0,
    LT_F      = 3'd1,
    LT_DOLLAR = 3'd2,
    LT_X      = 3'd3,
    LT_Y      = 3'd4,
    LT_Z      = 3'd5,
    LT_M      = 3'd6
  } letter_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_CMD  = 3'd1,
    PH_SIGN = 3'd2,
    PH_INT  = 3'd3,
    PH_FRAC = 3'd4,
    PH_SKIP = 3'd5
  } phase_e;

  // one classified character, front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       is_end;
    logic       is_upper;
    logic       is_digit;
    logic       is_minus;
    logic       is_plus;
    logic       is_point;
    logic       starts_word;
    letter_e    letter;
    logic [3:0] digit;
  } tok_t;

  // powers of ten up to 10^6
  function automatic logic [19:0] gwl_pow10(input logic [3:0] n);
    logic [19:0] r;
    case (n)
      4'd0:    r = 20'd1;
      4'd1:    r = 20'd10;
      4'd2:    r = 20'd100;
      4'd3:    r = 20'd1000;
      4'd4:    r = 20'd10000;
      4'd5:    r = 20'd100000;
      4'd6:    r = 20'd1000000;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/gwl_front.sv
// Front end: accepts characters and classifies them into tokens.
// Depends on gwl_pkg.
`timescale 1ns / 1ps

module gwl_front (
  input  logic          s_valid_i,
  output logic          s_ready_o,
  input  logic [7:0]    ch_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output gwl_pkg::tok_t q_tok_o
);
  import gwl_pkg::*;

  assign s_ready_o = !q_full_i;
  assign q_push_o  = s_valid_i && !q_full_i;

  always_comb begin
    q_tok_o             = '0;
    q_tok_o.ch          = ch_i;
    q_tok_o.is_end      = (ch_i == CH_NUL);
    q_tok_o.is_upper    = (ch_i >= CH_A) && (ch_i <= CH_Z);
    q_tok_o.is_digit    = (ch_i >= CH_0) && (ch_i <= CH_9);
    q_tok_o.is_minus    = (ch_i == CH_MINUS);
    q_tok_o.is_plus     = (ch_i == CH_PLUS);
    q_tok_o.is_point    = (ch_i == CH_POINT);
    q_tok_o.digit       = 4'(ch_i - CH_0);
    q_tok_o.starts_word = 1'b1;
    case (ch_i)
      CH_G:      q_tok_o.letter = LT_G;
      CH_F:      q_tok_o.letter = LT_F;
      CH_DOLLAR: q_tok_o.letter = LT_DOLLAR;
      CH_X:      q_tok_o.letter = LT_X;
      CH_Y:      q_tok_o.letter = LT_Y;
      CH_Z:      q_tok_o.letter = LT_Z;
      CH_M:      q_tok_o.letter = LT_M;
      default: begin
        q_tok_o.letter      = LT_G;
        q_tok_o.starts_word = 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/core/gwl_tok_queue.sv
// Short token queue between front and back ends.
// Depends on gwl_pkg.
`timescale 1ns / 1ps

module gwl_tok_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gwl_pkg::tok_t tok_i,
  input  logic          pop_i,
  output gwl_pkg::tok_t tok_o,
  output logic          full_o,
  output logic          empty_o
);
  import gwl_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  tok_t          slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign tok_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= tok_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("token queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("token queue pop while empty");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("token queue count did not advance");

endmodule

FILE: rtl/core/gwl_back.sv
// Back end: word scanner with value accumulation, motion tracking and
// the result register. Depends on gwl_pkg.
`timescale 1ns / 1ps

module gwl_back #(
  parameter int FRAC_DIGITS = gwl_pkg::FRAC_DIGITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  gwl_pkg::tok_t q_tok_i,
  output logic          q_pop_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output logic          word_valid_o,
  output logic [2:0]    word_letter_o,
  output logic [7:0]    cmd_char_o,
  output logic [31:0]   value_milli_o,
  output logic          line_end_o,
  output logic          line_moves_o
);
  import gwl_pkg::*;

  localparam int          FW     = $clog2(FRAC_DIGITS + 1);
  localparam logic [19:0] SCALE  = gwl_pow10(4'(FRAC_DIGITS));
  localparam logic [31:0] G28_LO = 32'(G_HOME * SCALE);
  localparam logic [31:0] G28_HI = 32'((G_HOME + 1) * SCALE);

  phase_e        ph_q, ph_d;
  letter_e       let_q, let_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [31:0]   acc_q, acc_d;
  logic          neg_q, neg_d;
  logic [FW-1:0] frac_q, frac_d;
  logic          mot_q, mot_d;

  logic          out_vld_q;
  logic          wv_q, le_q, lm_q;
  logic [2:0]    wl_q;
  logic [7:0]    wc_q;
  logic [31:0]   wval_q;

  logic          pop, in_word, word_done, has_res, word_motion;
  logic [31:0]   word_val, int_acc, frac_acc;
  logic [35:0]   int_sum, frac_sum;
  logic [23:0]   frac_add;
  logic          r_wv, r_le, r_lm;
  logic [2:0]    r_wl;
  logic [7:0]    r_wc;
  logic [31:0]   r_val;

  // advance when the result register is free or being drained
  assign pop     = !q_empty_i && (!out_vld_q || m_ready_i);
  assign q_pop_o = pop;

  assign in_word   = (ph_q == PH_SIGN) || (ph_q == PH_INT) ||
                     (ph_q == PH_FRAC) || (ph_q == PH_SKIP);
  assign word_done = pop && ((in_word && (q_tok_i.is_end || q_tok_i.is_upper)) ||
                             (ph_q == PH_CMD && q_tok_i.is_end));
  assign has_res   = word_done || (pop && q_tok_i.is_end);

  assign int_sum  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) +
                    (36'(q_tok_i.digit) * 36'(SCALE));
  assign frac_add = q_tok_i.digit * gwl_pow10(4'(FRAC_DIGITS - 1) - 4'(frac_q));
  assign frac_sum = {4'b0, acc_q} + 36'(frac_add);
  assign int_acc  = (int_sum  > 36'(MAG_CAP)) ? MAG_CAP : int_sum[31:0];
  assign frac_acc = (frac_sum > 36'(MAG_CAP)) ? MAG_CAP : frac_sum[31:0];

  assign word_val    = neg_q ? (32'd0 - acc_q) : (acc_q[31] ? POS_MAX : acc_q);
  assign word_motion = (let_q == LT_X) || (let_q == LT_Y) || (let_q == LT_Z) ||
                       ((let_q == LT_G) && !neg_q && (acc_q >= G28_LO) &&
                        (acc_q < G28_HI));

  // result of the current token
  always_comb begin
    r_wv  = word_done;
    r_wl  = word_done ? let_q : 3'd0;
    r_wc  = word_done ? cmd_q : 8'd0;
    r_val = word_done ? word_val : 32'd0;
    r_le  = q_tok_i.is_end;
    r_lm  = q_tok_i.is_end && (mot_q || (word_done && word_motion));
  end

  // scanner next state
  always_comb begin
    logic go_idle;
    go_idle = 1'b0;
    ph_d    = ph_q;
    let_d   = let_q;
    cmd_d   = cmd_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    frac_d  = frac_q;
    mot_d   = mot_q;
    if (pop) begin
      case (ph_q)
        PH_SIGN, PH_INT, PH_FRAC, PH_SKIP: begin
          if (q_tok_i.is_end || q_tok_i.is_upper) begin
            if (word_motion) mot_d = 1'b1;
            go_idle = 1'b1;
          end else begin
            case (ph_q)
              PH_SIGN: begin
                if (q_tok_i.is_minus) begin
                  neg_d = 1'b1;
                  ph_d  = PH_INT;
                end else if (q_tok_i.is_plus) begin
                  ph_d = PH_INT;
                end else if (q_tok_i.is_point) begin
                  ph_d = PH_FRAC;
                end else if (q_tok_i.is_digit) begin
                  acc_d = int_acc;
                  ph_d  = PH_INT;
                end else begin
                  ph_d = PH_SKIP;
                end
              end
              PH_INT: begin
                if (q_tok_i.is_digit) acc_d = int_acc;
                else if (q_tok_i.is_point) ph_d = PH_FRAC;
                else ph_d = PH_SKIP;
              end
              PH_FRAC: begin
                if (q_tok_i.is_digit) begin
                  if (frac_q < FW'(FRAC_DIGITS)) begin
                    acc_d  = frac_acc;
                    frac_d = frac_q + 1'b1;
                  end
                end else begin
                  ph_d = PH_SKIP;
                end
              end
              default: ph_d = PH_SKIP;
            endcase
          end
        end
        PH_CMD: begin
          if (q_tok_i.is_end) begin
            go_idle = 1'b1;
          end else begin
            cmd_d = q_tok_i.ch;
            ph_d  = PH_SIGN;
          end
        end
        default: go_idle = 1'b1;
      endcase

      if (go_idle) begin
        if (q_tok_i.is_end) begin
          ph_d   = PH_IDLE;
          let_d  = LT_G;
          cmd_d  = '0;
          acc_d  = '0;
          neg_d  = 1'b0;
          frac_d = '0;
          mot_d  = 1'b0;
        end else if (q_tok_i.starts_word) begin
          let_d  = q_tok_i.letter;
          cmd_d  = '0;
          acc_d  = '0;
          neg_d  = 1'b0;
          frac_d = '0;
          ph_d   = (q_tok_i.letter == LT_DOLLAR) ? PH_CMD : PH_SIGN;
        end else begin
          ph_d = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_IDLE;
      let_q     <= LT_G;
      cmd_q     <= '0;
      acc_q     <= '0;
      neg_q     <= 1'b0;
      frac_q    <= '0;
      mot_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      let_q  <= let_d;
      cmd_q  <= cmd_d;
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      frac_q <= frac_d;
      mot_q  <= mot_d;
      if (pop && has_res) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && has_res) begin
      wv_q   <= r_wv;
      wl_q   <= r_wl;
      wc_q   <= r_wc;
      wval_q <= r_val;
      le_q   <= r_le;
      lm_q   <= r_lm;
    end
  end

  assign m_valid_o     = out_vld_q;
  assign word_valid_o  = wv_q;
  assign word_letter_o = wl_q;
  assign cmd_char_o    = wc_q;
  assign value_milli_o = wval_q;
  assign line_end_o    = le_q;
  assign line_moves_o  = lm_q;

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && !line_end_o) |-> word_valid_o)
    else $error("result without word or line end");
  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_tok_i.is_end) |=> (ph_q == PH_IDLE && !mot_q && acc_q == '0))
    else $error("state not cleared after line end");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_ready_i) |-> !pop)
    else $error("token consumed while result stalled");
  a_moves_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && line_moves_o) |-> line_end_o)
    else $error("motion flag outside line end");

endmodule

FILE: rtl/core/gcode_word_lexer_core.sv
// G-code word lexer top level: front classifier, token queue, back scanner.
// Depends on gwl_pkg, gwl_front, gwl_tok_queue, gwl_back.
`timescale 1ns / 1ps

// Lexes a G-code line one character per cycle when neither side stalls. Send
// ASCII characters on the slave stream, ending each line with the byte 0. Words
// start at G, F, $, X, Y, Z or M (anything else outside a word is dropped);
// after '$' the next character is the command character. The number after the
// letter is an optional sign, integer digits and, after a point, fraction
// digits; extra fraction digits are truncated, and anything else ends the
// number and the rest of the word is skipped up to the next upper-case letter
// or the line end. A word is emitted when its terminator arrives, as a letter
// code and a value scaled by 10^FRAC_DIGITS (thousandths by default),
// saturated to 32 bits. The line end gives a result with tlast high and a
// motion flag (X, Y or Z word, or G28); a word closed by the line end shares
// that result. Throughput is one character per clock when neither side stalls,
// with the back end's multiply-add on the accumulator combinational; a result
// is presented once its character has been written into the token queue and
// the back end has then loaded the result register. The slave side keeps
// accepting while a result waits on the master side, until the two-entry token queue fills.
module gcode_word_lexer_core #(
  parameter int FRAC_DIGITS = gwl_pkg::FRAC_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] word_valid, [3:1] word_letter, [11:4] cmd_char, [43:12] value_milli,
  // [44] line_moves, [47:45] zero
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast    // line_end
);
  import gwl_pkg::*;

  tok_t        push_tok, pop_tok;
  logic        q_push, q_pop, q_full, q_empty;
  logic        word_valid, line_end, line_moves;
  logic [2:0]  word_letter;
  logic [7:0]  cmd_char;
  logic [31:0] value_milli;

  // classify and hand each character to the queue
  gwl_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .ch_i      (s_axis_tdata),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_tok_o   (push_tok)
  );

  // decouple the two sides so each can stall alone
  gwl_tok_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .tok_i   (push_tok),
    .pop_i   (q_pop),
    .tok_o   (pop_tok),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // scan words, accumulate values, hold the result register
  gwl_back #(
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_tok_i       (pop_tok),
    .q_pop_o       (q_pop),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .word_valid_o  (word_valid),
    .word_letter_o (word_letter),
    .cmd_char_o    (cmd_char),
    .value_milli_o (value_milli),
    .line_end_o    (line_end),
    .line_moves_o  (line_moves)
  );

  assign m_axis_tdata = {3'b000, line_moves, value_milli, cmd_char, word_letter, word_valid};
  assign m_axis_tlast = line_end;

endmodule

FILE: test/gcode_word_lexer_core_tb.sv
// Self-checking testbench for gcode_word_lexer_core: streams G-code lines in,
// predicts each emitted word and line end, compares them field by field.
// Depends on gwl_pkg and the gcode_word_lexer_core RTL.
`timescale 1ns / 1ps

module gcode_word_lexer_core_tb;
  import gwl_pkg::*;

  localparam int FRAC      = FRAC_DIGITS_DEF;
  localparam int CYCLE_CAP = 500000;

  typedef struct packed {
    logic       wv;
    letter_e    letter;
    logic [7:0] cmd;
    logic [31:0] val;
    logic       last;
    logic       moves;
  } word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       hold;   // wait for all pending words before sending
  } char_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  char_item_t line_chars[$];
  word_t      pending_words[$];
  int         errs;
  int         cycles;
  int         n_chars;
  bit         hold_next;
  bit         src_burst;
  bit         sink_burst;
  logic [3:0] src_wait;
  logic [3:0] sink_wait;

  // lexer state mirrored by the predictor
  phase_e      lex_phase;
  letter_e     lex_letter;
  logic [7:0]  lex_cmd;
  logic [31:0] lex_mag;
  logic        lex_neg;
  int          lex_frac;
  logic        lex_motion;

  gcode_word_lexer_core #(.FRAC_DIGITS(FRAC)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] ten_pow(input int n);
    logic [63:0] r;
    r = 64'd1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

  function automatic void lex_clear();
    lex_phase  = PH_IDLE;
    lex_letter = LT_G;
    lex_cmd    = '0;
    lex_mag    = '0;
    lex_neg    = 1'b0;
    lex_frac   = 0;
    lex_motion = 1'b0;
  endfunction

  function automatic void add_mag(input logic [63:0] v);
    lex_mag = (v > {32'd0, MAG_CAP}) ? MAG_CAP : v[31:0];
  endfunction

  function automatic void take_digit(input logic [7:0] c, input bit frac);
    logic [63:0] d;
    d = {56'd0, c - CH_0};
    if (!frac) begin
      add_mag({32'd0, lex_mag} * 10 + d * ten_pow(FRAC));
    end else if (lex_frac < FRAC) begin
      add_mag({32'd0, lex_mag} + d * ten_pow(FRAC - 1 - lex_frac));
      lex_frac++;
    end
  endfunction

  // Close the word in progress and note motion (X/Y/Z, or G with integer part 28).
  function automatic void close_word(inout word_t w);
    logic [63:0] scale;
    scale    = ten_pow(FRAC);
    w.wv     = 1'b1;
    w.letter = lex_letter;
    w.cmd    = lex_cmd;
    if (lex_neg) w.val = 32'd0 - lex_mag;
    else w.val = (lex_mag > POS_MAX) ? POS_MAX : lex_mag;
    if (lex_letter == LT_X || lex_letter == LT_Y || lex_letter == LT_Z) lex_motion = 1'b1;
    if (lex_letter == LT_G && !lex_neg && {32'd0, lex_mag} >= G_HOME * scale &&
        {32'd0, lex_mag} < (G_HOME + 1) * scale) lex_motion = 1'b1;
  endfunction

  // Advance the lexer by one character; returns 1 when a result is due.
  function automatic bit lex_char(input logic [7:0] c, output word_t w);
    bit     upper;
    bit     dig;
    bit     emitted;
    phase_e ph;
    w       = '0;
    emitted = 1'b0;
    upper   = (c >= CH_A && c <= CH_Z);
    dig     = (c >= CH_0 && c <= CH_9);
    ph      = lex_phase;
    if (ph >= PH_SIGN) begin
      if (c == CH_NUL || upper) begin
        close_word(w);
        emitted = 1'b1;
        ph      = PH_IDLE;
      end else begin
        case (ph)
          PH_SIGN: begin
            if (c == CH_MINUS) begin
              lex_neg = 1'b1;
              ph      = PH_INT;
            end else if (c == CH_PLUS) begin
              ph = PH_INT;
            end else if (c == CH_POINT) begin
              ph = PH_FRAC;
            end else if (dig) begin
              take_digit(c, 1'b0);
              ph = PH_INT;
            end else begin
              ph = PH_SKIP;
            end
          end
          PH_INT: begin
            if (dig) take_digit(c, 1'b0);
            else if (c == CH_POINT) ph = PH_FRAC;
            else ph = PH_SKIP;
          end
          PH_FRAC: begin
            if (dig) take_digit(c, 1'b1);
            else ph = PH_SKIP;
          end
          default: ;
        endcase
        lex_phase = ph;
        return 1'b0;
      end
    end else if (ph == PH_CMD) begin
      if (c == CH_NUL) begin
        // dollar cut off by the line end: command 0, value 0
        lex_mag = '0;
        lex_neg = 1'b0;
        lex_cmd = '0;
        close_word(w);
        emitted = 1'b1;
        ph      = PH_IDLE;
      end else begin
        lex_cmd   = c;
        lex_phase = PH_SIGN;
        return 1'b0;
      end
    end

    if (c == CH_NUL) begin
      w.last  = 1'b1;
      w.moves = lex_motion;
      lex_clear();
      return 1'b1;
    end
    if (c == CH_G || c == CH_F || c == CH_DOLLAR || c == CH_X || c == CH_Y ||
        c == CH_Z || c == CH_M) begin
      case (c)
        CH_G:      lex_letter = LT_G;
        CH_F:      lex_letter = LT_F;
        CH_DOLLAR: lex_letter = LT_DOLLAR;
        CH_X:      lex_letter = LT_X;
        CH_Y:      lex_letter = LT_Y;
        CH_Z:      lex_letter = LT_Z;
        default:   lex_letter = LT_M;
      endcase
      lex_cmd  = '0;
      lex_mag  = '0;
      lex_neg  = 1'b0;
      lex_frac = 0;
      ph       = (c == CH_DOLLAR) ? PH_CMD : PH_SIGN;
    end
    lex_phase = ph;
    return emitted;
  endfunction

  function automatic logic [3:0] idle_draw(input bit burst);
    return burst ? 4'd0 : 4'($urandom_range(0, 15));
  endfunction

  task automatic push_char(input logic [7:0] c);
    line_chars.push_back('{ch: c, hold: hold_next});
    hold_next = 1'b0;
    n_chars++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_digits(input int n);
    for (int i = 0; i < n; i++) push_char(8'($urandom_range(CH_0, CH_9)));
  endtask

  task automatic cmp(input string what, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, e, a);
      errs++;
    end
  endtask

  // Sender: present one character at a time, with a random gap after each.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    word_t      w;
    logic       nxt_valid;
    logic [3:0] nxt_wait;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_wait      <= '0;
    end else begin
      nxt_valid = s_axis_tvalid;
      nxt_wait  = src_wait;
      if (s_axis_tvalid && s_axis_tready) begin
        if (lex_char(s_axis_tdata, w)) pending_words.push_back(w);
        if ($urandom_range(0, 39) == 0) src_burst = !src_burst;
        nxt_valid = 1'b0;
        nxt_wait  = idle_draw(src_burst);
      end else if (!s_axis_tvalid && nxt_wait != 0) begin
        nxt_wait = nxt_wait - 4'd1;
      end
      if (!nxt_valid && nxt_wait == 0 && line_chars.size() != 0 &&
          !(line_chars[0].hold && pending_words.size() != 0)) begin
        nxt_valid    = 1'b1;
        s_axis_tdata <= line_chars[0].ch;
        void'(line_chars.pop_front());
      end
      s_axis_tvalid <= nxt_valid;
      src_wait      <= nxt_wait;
    end
  end

  // Receiver: check each accepted result, then stall a random number of cycles.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    word_t      e;
    logic [3:0] nxt_wait;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= '0;
    end else begin
      nxt_wait = sink_wait;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata 0x%0h tlast %0b",
                   $time, m_axis_tdata, m_axis_tlast);
          errs++;
        end else begin
          e = pending_words.pop_front();
          cmp("word_valid", 32'(e.wv), 32'(m_axis_tdata[0]));
          cmp("word_letter", 32'(e.letter), 32'(m_axis_tdata[3:1]));
          cmp("cmd_char", 32'(e.cmd), 32'(m_axis_tdata[11:4]));
          cmp("value_milli", e.val, m_axis_tdata[43:12]);
          cmp("line_moves", 32'(e.moves), 32'(m_axis_tdata[44]));
          cmp("pad bits", 32'd0, 32'(m_axis_tdata[47:45]));
          cmp("line_end", 32'(e.last), 32'(m_axis_tlast));
        end
        if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
        nxt_wait = idle_draw(sink_burst);
      end else if (nxt_wait != 0) begin
        nxt_wait = nxt_wait - 4'd1;
      end
      m_axis_tready <= (nxt_wait == 0);
      sink_wait     <= nxt_wait;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stim
    logic [7:0] lc;
    int         n_words;
    bit         cut;
    clk_i      = 1'b0;
    rst_ni     = 1'b0;
    errs       = 0;
    cycles     = 0;
    n_chars    = 0;
    hold_next  = 1'b0;
    src_burst  = 1'b0;
    sink_burst = 1'b0;
    lex_clear();

    // G28 motion, negative X with truncated fraction, dollar cut by line end
    push_str("G28X-1.2345$");
    push_char(CH_NUL);
    // empty line
    push_char(CH_NUL);
    // positive saturation, sign after the number, empty Y closed by line end,
    // and a top-bit byte outside any word
    push_char(8'hFF);
    push_str("F9999999M+.5-Y");
    push_char(CH_NUL);
    // negative saturation with a command letter
    push_str("$J-3000000");
    push_char(CH_NUL);

    hold_next = 1'b1;
    while (n_chars < 1680) begin
      if (n_chars > 900 && n_chars < 960) hold_next = 1'b1;
      n_words = $urandom_range(0, 5);
      cut     = 1'b0;
      for (int wi = 0; wi < n_words && !cut; wi++) begin
        if ($urandom_range(0, 9) == 0) push_char(8'($urandom_range(1, 255)));
        if ($urandom_range(0, 11) == 0) push_char(8'($urandom_range(CH_A, CH_Z)));
        case ($urandom_range(0, 6))
          0:       lc = CH_G;
          1:       lc = CH_F;
          2:       lc = CH_DOLLAR;
          3:       lc = CH_X;
          4:       lc = CH_Y;
          5:       lc = CH_Z;
          default: lc = CH_M;
        endcase
        push_char(lc);
        if (lc == CH_DOLLAR) begin
          if (wi == n_words - 1 && $urandom_range(0, 3) == 0) begin
            cut = 1'b1;
            continue;
          end
          push_char($urandom_range(0, 1) ? 8'($urandom_range(CH_A, CH_Z))
                                         : 8'($urandom_range(1, 255)));
        end
        case ($urandom_range(0, 3))
          0:       push_char(CH_MINUS);
          1:       push_char(CH_PLUS);
          default: ;
        endcase
        if (lc == CH_G && $urandom_range(0, 2) == 0) push_str("28");
        else if ($urandom_range(0, 7) == 0) push_digits($urandom_range(7, 12));
        else push_digits($urandom_range(0, 3));
        if ($urandom_range(0, 1)) begin
          push_char(CH_POINT);
          push_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 5) == 0) begin
          push_char(8'($urandom_range(1, 255)));
          push_digits($urandom_range(0, 2));
        end
        if ($urandom_range(0, 2) == 0) push_char(8'h20);
      end
      push_char(CH_NUL);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (line_chars.size() != 0 || s_axis_tvalid || pending_words.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errs == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/gwl_pkg.sv
rtl/core/gwl_front.sv
rtl/core/gwl_tok_queue.sv
rtl/core/gwl_back.sv
rtl/core/gcode_word_lexer_core.sv
test/gcode_word_lexer_core_tb.sv
